FILE: rtl/core/jse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the sequential JPEG coefficient expander.
// No dependencies; every other file of the block but jse_if imports this package.

package jse_pkg;

	// Input op codes
	localparam logic OP_DC = 1'b0;
	localparam logic OP_AC = 1'b1;

	// Zigzag index state: 64 means no block is open
	localparam logic [6:0] NO_BLOCK = 7'd64;
	localparam logic [5:0] LAST_ZZ  = 6'd63;

	// AC symbol decoding
	localparam logic [3:0] ZRL_RUN  = 4'hF;
	localparam logic [5:0] ZRL_SPAN = 6'd15;
	// Highest open index that still fits a 16-zero run
	localparam logic [5:0] ZRL_MAX_START = 6'd48;

	// Command from front to back: emit span+1 results at zigzag start..start+span.
	// With has_value the final one carries value, all others are zero.
	typedef struct packed {
		logic [5:0]  start;
		logic [5:0]  span;
		logic        has_value;
		logic [15:0] value;
		logic        err;
	} jse_cmd_t;

	// Zigzag order to natural row-major position
	localparam logic [5:0] ZZ_TO_NAT [64] = '{
		6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
		6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
		6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
		6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
		6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
		6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
		6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
		6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
	};

endpackage

`default_nettype wire

FILE: rtl/core/jse_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces: decoded symbols in, coefficients out.
// No dependencies.

interface jse_sym_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [7:0]  symbol;
	logic [15:0] extra_bits;

	modport source (output valid, op, symbol, extra_bits, input ready);
	modport sink   (input valid, op, symbol, extra_bits, output ready);
endinterface

interface jse_coef_if;
	logic               valid;
	logic               ready;
	logic [5:0]         position;
	logic signed [15:0] coefficient;
	logic               last_of_block;
	logic               error;

	modport source (output valid, position, coefficient, last_of_block, error, input ready);
	modport sink   (input valid, position, coefficient, last_of_block, error, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/jse_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// Two-entry command queue between the symbol front end and the expander.
// Depends on jse_pkg for the command type.

module jse_cmd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  jse_pkg::jse_cmd_t   push_cmd,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output jse_pkg::jse_cmd_t   head
);
	import jse_pkg::*;

	jse_cmd_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head  = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("command queue underflow");

endmodule

`default_nettype wire

FILE: rtl/core/jse_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front end: accepts symbol transactions, tracks the block position and DC
// predictor, and turns each symbol into one expansion command. Uses jse_pkg.

module jse_front #(
	parameter int COEFF_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	jse_sym_if.sink            sym,
	input  logic               full,
	output logic               push,
	output jse_pkg::jse_cmd_t  cmd
);
	import jse_pkg::*;

	localparam int SH = 16 - COEFF_BITS;

	// Wrap to COEFF_BITS and sign-extend into the 16-bit field
	function automatic logic [15:0] sext(input logic [COEFF_BITS-1:0] v);
		logic signed [15:0] t;
		t = $signed(16'(v) << SH);
		return 16'(t >>> SH);
	endfunction

	logic [6:0]            idx_q;
	logic [COEFF_BITS-1:0] dc_q;

	logic [3:0]            size;
	logic [3:0]            run;
	logic [5:0]            i6;
	logic                  blk_open;
	logic [15:0]           mask;
	logic [15:0]           raw;
	logic [15:0]           half;
	logic [15:0]           ext;
	logic [COEFF_BITS-1:0] dc_sum;
	logic [6:0]            idx_next;
	logic [6:0]            run_end;

	assign size     = sym.symbol[3:0];
	assign run      = sym.symbol[7:4];
	assign i6       = idx_q[5:0];
	assign blk_open = !idx_q[6] && (i6 != 6'd0);
	assign run_end  = 7'(i6) + 7'(run);

	assign sym.ready = !full;
	assign push      = sym.valid && !full;

	// EXTEND of the additional bits, then DC prediction
	always_comb begin
		mask = (16'd1 << size) - 16'd1;
		raw  = sym.extra_bits & mask;
		half = 16'd1 << (size - 4'd1);
		if (size == 4'd0) begin
			ext = 16'd0;
		end else if (raw < half) begin
			ext = raw - (16'd1 << size) + 16'd1;
		end else begin
			ext = raw;
		end
		dc_sum = dc_q + ext[COEFF_BITS-1:0];
	end

	// Symbol classification into a command
	always_comb begin
		cmd       = '0;
		idx_next  = NO_BLOCK;
		if (sym.op == OP_DC) begin
			cmd.has_value = 1'b1;
			cmd.value     = sext(dc_sum);
			idx_next      = 7'd1;
		end else if (!blk_open) begin
			cmd.err = 1'b1;
		end else if (size == 4'd0 && run != ZRL_RUN) begin
			// end of block: zeros through the last position
			cmd.start = i6;
			cmd.span  = LAST_ZZ - i6;
		end else if (size == 4'd0) begin
			// zero run of sixteen
			if (i6 > ZRL_MAX_START) begin
				cmd.err = 1'b1;
			end else begin
				cmd.start = i6;
				cmd.span  = ZRL_SPAN;
				idx_next  = idx_q + 7'd16;
			end
		end else if (run_end > 7'(LAST_ZZ)) begin
			cmd.err = 1'b1;
		end else begin
			cmd.start     = i6;
			cmd.span      = 6'(run);
			cmd.has_value = 1'b1;
			cmd.value     = sext(ext[COEFF_BITS-1:0]);
			idx_next      = run_end + 7'd1;
		end
	end

	// Block position and predictor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= NO_BLOCK;
			dc_q  <= '0;
		end else if (push) begin
			idx_q <= idx_next;
			if (sym.op == OP_DC) begin
				dc_q <= dc_sum;
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 7'd0 && idx_q <= NO_BLOCK) else $error("zigzag index out of range");

endmodule

`default_nettype wire

FILE: rtl/core/jse_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back end: walks the head command one coefficient per cycle into the output
// register unless coef stalls. Uses jse_pkg for the command type and zigzag table.

module jse_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  jse_pkg::jse_cmd_t  head,
	output logic               pop,
	jse_coef_if.source         coef
);
	import jse_pkg::*;

	logic        ov_q;
	logic [5:0]  k_q;
	logic [5:0]  pos_q;
	logic [15:0] coef_q;
	logic        last_q;
	logic        err_q;

	logic        load;
	logic        fin;
	logic [5:0]  zz;

	assign load = !empty && (!ov_q || coef.ready);
	assign fin  = k_q == head.span;
	assign zz   = head.start + k_q;
	assign pop  = load && fin;

	assign coef.valid         = ov_q;
	assign coef.position      = pos_q;
	assign coef.coefficient   = coef_q;
	assign coef.last_of_block = last_q;
	assign coef.error         = err_q;

	// Output payload
	always_ff @(posedge clk) begin
		if (load) begin
			pos_q  <= ZZ_TO_NAT[zz];
			coef_q <= (head.has_value && fin) ? head.value : 16'd0;
			last_q <= head.err || (zz == LAST_ZZ);
			err_q  <= head.err;
		end
	end

	// Output valid and offset within the command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			k_q  <= 6'd0;
		end else if (load) begin
			ov_q <= 1'b1;
			k_q  <= fin ? 6'd0 : k_q + 6'd1;
		end else if (coef.ready) begin
			ov_q <= 1'b0;
		end
	end

	a_offset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> k_q == 6'd0) else $error("offset left over without command");
	a_error_shape: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && err_q |-> pos_q == 6'd0 && coef_q == 16'd0 && last_q)
		else $error("malformed error result");

endmodule

`default_nettype wire

FILE: rtl/core/jpeg_sequential_coeff_expander.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequential JPEG run-length coefficient expander.
// Channel sym takes Huffman-decoded symbols: op (DC starts a block, AC is a
// run/size byte) with right-aligned extra_bits. Channel coef gives the block's
// coefficients in zigzag order with natural position, last_of_block on the
// final one and error on an overrun or an AC symbol outside a block.
// Both are valid/ready; a transaction happens when valid and ready are high.
// A symbol is taken whenever the two-entry command queue has room; its
// command passes through the queue, and its results come from the output
// register. The expander emits one coefficient per cycle while coef does
// not stall, and a symbol yields 1 to 63 results, the zero count of a run
// or end-of-block setting it.
// When coef stalls, the result holds in the output register and the queue
// absorbs up to two more symbols before sym.ready drops.
// Reset clears the DC predictor to zero, closes any block and empties the
// queue and output register.
// Depends on jse_pkg, jse_if, jse_cmd_fifo, jse_front and jse_back.

module jpeg_sequential_coeff_expander #(
	parameter int COEFF_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	jse_sym_if.sink     sym,
	jse_coef_if.source  coef
);
	import jse_pkg::*;

	jse_cmd_t push_cmd;
	jse_cmd_t head;
	logic     push;
	logic     pop;
	logic     full;
	logic     empty;

	jse_front #(
		.COEFF_BITS(COEFF_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sym    (sym),
		.full   (full),
		.push   (push),
		.cmd    (push_cmd)
	);

	jse_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	jse_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.coef   (coef)
	);

endmodule

`default_nettype wire

FILE: verif/jse_coeff_checker.sv
`timescale 1ns / 1ps
// Coefficient checker for the sequential JPEG coefficient expander: predicts
// the results of every accepted symbol and compares them on the coef channel.
// Depends on jse_pkg and jse_if.

module jse_coeff_checker #(
	parameter int COEFF_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	jse_sym_if   sym,
	jse_coef_if  coef,
	output int   fail_count,
	output int   pending
);
	import jse_pkg::*;

	typedef struct packed {
		logic [5:0]         pos;
		logic signed [15:0] coeff;
		logic               last;
		logic               err;
	} coeff_result_t;

	coeff_result_t coeff_q[$];
	logic [15:0]   dc_pred  = '0;
	logic [6:0]    zz_next  = NO_BLOCK;
	int            failures = 0;

	// Wrap to COEFF_BITS two's complement, sign-extend into 16 bits
	function automatic logic [15:0] wrap_to_width(logic [31:0] v);
		logic [31:0] mask;
		mask = (32'd1 << COEFF_BITS) - 32'd1;
		v    = v & mask;
		if (v[COEFF_BITS-1])
			v = v | ~mask;
		return v[15:0];
	endfunction

	// Magnitude category decode of the additional bits
	function automatic logic [31:0] extend_value(logic [15:0] raw, logic [3:0] size);
		logic [31:0] v;
		if (size == 4'd0)
			return 32'd0;
		v = {16'd0, raw} & ((32'd1 << size) - 32'd1);
		if (v < (32'd1 << (size - 1)))
			v = v - (32'd1 << size) + 32'd1;
		return v;
	endfunction

	task automatic push_result(logic [5:0] zz, logic [15:0] c, logic last, logic err);
		coeff_result_t r;
		r.pos   = ZZ_TO_NAT[zz];
		r.coeff = c;
		r.last  = last;
		r.err   = err;
		coeff_q.push_back(r);
	endtask

	task automatic push_error();
		push_result(6'd0, 16'd0, 1'b1, 1'b1);
		zz_next = NO_BLOCK;
	endtask

	// Expected results of one symbol, in zigzag order
	task automatic expand_symbol(logic op, logic [7:0] s, logic [15:0] bits);
		logic [3:0] size;
		logic [3:0] run;
		logic [6:0] zz;
		size = s[3:0];
		run  = s[7:4];
		zz   = zz_next;

		// DC starts a new block, dropping any open one
		if (op == OP_DC) begin
			dc_pred = wrap_to_width({16'd0, dc_pred} + extend_value(bits, size));
			push_result(6'd0, dc_pred, 1'b0, 1'b0);
			zz_next = 7'd1;
			return;
		end

		if (zz >= NO_BLOCK || zz == 7'd0) begin
			push_error();
			return;
		end

		// End of block: zero fill through the last position
		if (size == 4'd0 && run != ZRL_RUN) begin
			while (zz < 7'd64) begin
				push_result(zz[5:0], 16'd0, zz == 7'd63, 1'b0);
				zz++;
			end
			zz_next = NO_BLOCK;
			return;
		end

		// Sixteen zeros
		if (size == 4'd0) begin
			if (zz + 15 > 63) begin
				push_error();
				return;
			end
			repeat (16) begin
				push_result(zz[5:0], 16'd0, zz == 7'd63, 1'b0);
				zz++;
			end
			zz_next = (zz >= 7'd64) ? NO_BLOCK : zz;
			return;
		end

		// Zero run followed by one value
		if (zz + run > 63) begin
			push_error();
			return;
		end
		repeat (run) begin
			push_result(zz[5:0], 16'd0, 1'b0, 1'b0);
			zz++;
		end
		push_result(zz[5:0], wrap_to_width(extend_value(bits, size)), zz == 7'd63, 1'b0);
		zz++;
		zz_next = (zz >= 7'd64) ? NO_BLOCK : zz;
	endtask

	// Watch both channels; values sampled here are the ones of the edge
	always @(posedge clk) begin
		coeff_result_t want;
		if (!arst_n) begin
			coeff_q.delete();
			dc_pred = '0;
			zz_next = NO_BLOCK;
		end else begin
			if (sym.valid && sym.ready)
				expand_symbol(sym.op, sym.symbol, sym.extra_bits);
			if (coef.valid && coef.ready) begin
				if (coeff_q.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("%0t: unexpected result: pos %0d coef %0d last %0d err %0d",
							$time, coef.position, coef.coefficient,
							coef.last_of_block, coef.error);
				end else begin
					want = coeff_q.pop_front();
					if (want.pos !== coef.position || want.coeff !== coef.coefficient ||
						want.last !== coef.last_of_block || want.err !== coef.error) begin
						failures++;
						if (failures <= 10)
							$display("%0t: mismatch: expected pos %0d coef %0d last %0d err %0d, got pos %0d coef %0d last %0d err %0d",
								$time, want.pos, want.coeff, want.last, want.err,
								coef.position, coef.coefficient,
								coef.last_of_block, coef.error);
					end
				end
			end
		end
		fail_count <= failures;
		pending    <= coeff_q.size();
	end

endmodule

FILE: verif/tb_jpeg_sequential_coeff_expander.sv
`timescale 1ns / 1ps
// Testbench top for the sequential JPEG coefficient expander: drives symbols
// in bursts, stalls the coefficient side, and gives the verdict.
// Depends on jse_pkg, jse_if, jse_coeff_checker and the expander RTL.

module tb_jpeg_sequential_coeff_expander;
	import jse_pkg::*;

	localparam int          RANDOM_ITEMS = 200;
	localparam logic [7:0]  SYM_EOB      = 8'h00;
	localparam logic [7:0]  SYM_ZRL      = {ZRL_RUN, 4'h0};

	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic     clk;
	logic     arst_n;
	int       mismatches;
	int       pending;
	int       burst_left = 0;
	rx_mode_t rx_mode;
	int       rx_phase_left;

	jse_sym_if  sym_ch();
	jse_coef_if coef_ch();

	jpeg_sequential_coeff_expander #(.COEFF_BITS(16)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sym    (sym_ch),
		.coef   (coef_ch)
	);

	jse_coeff_checker #(.COEFF_BITS(16)) coeff_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym        (sym_ch),
		.coef       (coef_ch),
		.fail_count (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Receiver: stall pattern switches between modes after each random-length phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_ch.ready <= 1'b0;
			rx_mode       <= RX_OPEN;
			rx_phase_left <= 0;
		end else begin
			if (rx_phase_left == 0) begin
				rx_mode       <= rx_mode_t'($urandom_range(3));
				rx_phase_left <= $urandom_range(300, 40);
			end else begin
				rx_phase_left <= rx_phase_left - 1;
			end
			case (rx_mode)
				RX_OPEN:     coef_ch.ready <= 1'b1;
				RX_RANDOM:   coef_ch.ready <= 1'($urandom_range(1));
				RX_SPARSE:   coef_ch.ready <= ($urandom_range(3) == 0);
				RX_PERIODIC: coef_ch.ready <= (rx_phase_left[2:0] < 3'd5);
				default:     coef_ch.ready <= 1'b1;
			endcase
		end
	end

	// One symbol transaction; may open a gap when the current burst runs out
	task automatic send_symbol(input logic op, input logic [7:0] s, input logic [15:0] bits);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(30, 1);
			if (gap > 8)
				gap = $urandom_range(gap, 1);
			if (gap > 0) begin
				sym_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(16, 1);
		end
		sym_ch.valid      <= 1'b1;
		sym_ch.op         <= op;
		sym_ch.symbol     <= s;
		sym_ch.extra_bits <= bits;
		do @(posedge clk); while (!sym_ch.ready);
		burst_left--;
	endtask

	initial begin
		int         sent;
		int         pick;
		logic [6:0] zz;
		logic [3:0] run;
		logic [3:0] size;

		arst_n            = 1'b0;
		sym_ch.valid      = 1'b0;
		sym_ch.op         = OP_DC;
		sym_ch.symbol     = '0;
		sym_ch.extra_bits = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: AC outside a block, extremes of values, DC wrap
		send_symbol(OP_AC, SYM_EOB, 16'h0000);
		send_symbol(OP_DC, 8'h00, 16'hFFFF);
		send_symbol(OP_AC, 8'h01, 16'hFFFE);
		send_symbol(OP_AC, SYM_ZRL, 16'hFFFF);
		send_symbol(OP_AC, 8'h0F, 16'h8000);
		send_symbol(OP_AC, 8'h1F, 16'hFFFF);
		send_symbol(OP_AC, SYM_EOB, 16'hA5A5);
		send_symbol(OP_DC, 8'hFF, 16'hFFFF);
		send_symbol(OP_DC, 8'h0F, 16'h7FFF);
		// size zero with a short run closes like an end of block
		send_symbol(OP_AC, 8'h30, 16'h1234);

		// Zero run ending exactly on the last position
		send_symbol(OP_DC, 8'h01, 16'h0001);
		send_symbol(OP_AC, SYM_ZRL, 16'h0000);
		send_symbol(OP_AC, SYM_ZRL, 16'h0000);
		send_symbol(OP_AC, 8'hE1, 16'h0000);
		send_symbol(OP_AC, SYM_ZRL, 16'h0000);

		// Value run past the end of the block
		send_symbol(OP_DC, 8'h02, 16'h0002);
		send_symbol(OP_AC, SYM_ZRL, 16'h0000);
		send_symbol(OP_AC, SYM_ZRL, 16'h0000);
		send_symbol(OP_AC, SYM_ZRL, 16'h0000);
		send_symbol(OP_AC, 8'hF1, 16'h0001);

		// Zero run past the end
		send_symbol(OP_DC, 8'h03, 16'h0000);
		send_symbol(OP_AC, SYM_ZRL, 16'h0000);
		send_symbol(OP_AC, SYM_ZRL, 16'h0000);
		send_symbol(OP_AC, SYM_ZRL, 16'h0000);
		send_symbol(OP_AC, SYM_ZRL, 16'h0000);

		// Random: mostly well-formed blocks, some noise and abandoned blocks
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(9) == 0) begin
				send_symbol(1'($urandom_range(1)), 8'($urandom_range(255)),
					16'($urandom_range(65535)));
				sent++;
			end else begin
				send_symbol(OP_DC, 8'($urandom_range(255)), 16'($urandom_range(65535)));
				sent++;
				zz = 7'd1;
				while (zz < 7'd64 && sent < RANDOM_ITEMS) begin
					pick = $urandom_range(99);
					if (pick < 4)
						break;
					if (pick < 16) begin
						run = 4'($urandom_range(14));
						send_symbol(OP_AC, {run, 4'h0}, 16'($urandom_range(65535)));
						zz = 7'd64;
					end else if (pick < 28) begin
						send_symbol(OP_AC, SYM_ZRL, 16'($urandom_range(65535)));
						zz = (zz + 15 > 63) ? 7'd64 : zz + 7'd16;
					end else begin
						run  = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) :
							4'($urandom_range(2));
						size = 4'($urandom_range(15, 1));
						send_symbol(OP_AC, {run, size}, 16'($urandom_range(65535)));
						zz = (zz + run > 63) ? 7'd64 : zz + 7'(run) + 7'd1;
					end
					sent++;
				end
			end
		end
		sym_ch.valid <= 1'b0;

		// Let the checker count the last transaction, drain, then settle
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
